// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define PBA_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pool_block_allocator assertion failed");
`define PBA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("pool_block_allocator assertion failed");
`else
`define PBA_ASSERT(name, prop)
`define PBA_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== rtl/pba_pkg.sv =====
package pba_pkg;

  localparam int POOL_GRANULES   = 4096;
  localparam int ALIGN_BYTES     = 8;
  localparam int HEADER_GRANULES = 3;

  localparam int LINK_W = 13;
  localparam int IDX_W  = $clog2(POOL_GRANULES);
  localparam int SIZE_W = 16;
  localparam int ADDR_W = 15;
  localparam int NEED_W = SIZE_W + 1;
  localparam int DEND_W = ((LINK_W > NEED_W) ? LINK_W : NEED_W) + 2;
  localparam int AMUL_W = DEND_W + $clog2(ALIGN_BYTES) + 1;
  localparam int STEP_W = $clog2(POOL_GRANULES + 1) + 1;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_POOL_GRANULES = REG_IDX_W'(0);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic latch;
    logic splice1;
    logic splice2;
    logic unlink;
    logic rsp_load;
    logic rsp_ok;
  } pba_cmd_t;

  typedef struct packed {
    logic op_free;
    logic size_zero;
    logic free_bad;
    logic fit;
    logic walk_end;
  } pba_sts_t;

  function automatic logic in_table(input logic [LINK_W-1:0] idx);
    in_table = (32'(idx) < 32'(POOL_GRANULES));
  endfunction

endpackage

// ===== rtl/pba_req_if.sv =====
interface pba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [pba_pkg::SIZE_W-1:0]  size_bytes;
  logic [pba_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output operation, output size_bytes, output address,
                  input ready);
  modport sink (input valid, input operation, input size_bytes, input address,
                output ready);
endinterface

// ===== rtl/pba_rsp_if.sv =====
interface pba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pba_pkg::ADDR_W-1:0]  address_out;
  logic                        ok;

  modport source (output valid, output address_out, output ok, input ready);
  modport sink (input valid, input address_out, input ok, output ready);
endinterface

// ===== rtl/pba_ram.sv =====
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pba_ctrl.sv =====
`include "assert_macros.svh"

module pba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pba_pkg::pba_sts_t  sts,
  output pba_pkg::pba_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOOK = 7'b0000010,
    S_ACHK = 7'b0000100,
    S_WR1  = 7'b0001000,
    S_WR2  = 7'b0010000,
    S_FCHK = 7'b0100000,
    S_RESP = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   res_ok, res_ok_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    res_ok_next  = res_ok;
    cmd          = '0;
    cmd.rsp_ok   = res_ok;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.op_free) begin
          if (sts.free_bad) begin
            res_ok_next = 1'b0;
            state_next  = S_RESP;
          end else begin
            state_next = S_FCHK;
          end
        end else if (sts.size_zero) begin
          res_ok_next = 1'b0;
          state_next  = S_RESP;
        end else begin
          state_next = S_ACHK;
        end
      end
      S_ACHK: begin
        cmd.latch = 1'b1;
        if (sts.fit) begin
          res_ok_next = 1'b1;
          state_next  = S_WR1;
        end else if (sts.walk_end) begin
          res_ok_next = 1'b0;
          state_next  = S_RESP;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_WR1: begin
        cmd.splice1 = 1'b1;
        state_next  = S_WR2;
      end
      S_WR2: begin
        cmd.splice2 = 1'b1;
        state_next  = S_RESP;
      end
      S_FCHK: begin
        cmd.unlink  = 1'b1;
        res_ok_next = 1'b1;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          cmd.rsp_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_ok    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      res_ok <= res_ok_next;
      if (cmd.rsp_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PBA_ASSERT(a_accept_look, accept |=> state == S_LOOK)
  `PBA_ASSERT(a_fit_splice, state == S_ACHK && sts.fit |=> state == S_WR1 ##1 state == S_WR2)
  `PBA_ASSERT(a_no_overwrite, cmd.rsp_load |-> !out_valid || out_ready)

endmodule

// ===== rtl/pba_datapath.sv =====
`include "assert_macros.svh"

module pba_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  pba_pkg::pba_cmd_t            cmd,
  output pba_pkg::pba_sts_t            sts,
  input  logic                         operation,
  input  logic [pba_pkg::SIZE_W-1:0]   size_bytes,
  input  logic [pba_pkg::ADDR_W-1:0]   address,
  input  logic                         cfg_we,
  input  logic [pba_pkg::LINK_W-1:0]   cfg_value,
  output logic [pba_pkg::LINK_W-1:0]   pool_granules,
  output logic [pba_pkg::ADDR_W-1:0]   address_out,
  output logic                         ok
);

  localparam int LW = pba_pkg::LINK_W;
  localparam int IW = pba_pkg::IDX_W;
  localparam int DW = pba_pkg::DEND_W;
  localparam int AW = pba_pkg::ADDR_W;
  localparam int NW = pba_pkg::NEED_W;
  localparam int SW = pba_pkg::STEP_W;
  localparam int MW = pba_pkg::AMUL_W;

  logic [LW-1:0] anchor_prev, anchor_next, anchor_end;
  logic [IW-1:0] last_header;
  logic          op_free, size_zero, free_bad;
  logic [NW-1:0] need;
  logic [LW-1:0] pos;
  logic [SW-1:0] steps;
  logic [LW-1:0] hdr_q, nxt_q, dend_q;
  logic [AW-1:0] res_addr;

  logic [LW-1:0] prev_q, next_q, end_q;
  logic [LW-1:0] prev_v, next_v, end_v;
  logic [DW-1:0] data_v, dend_v;
  logic [MW-1:0] res_full;
  logic [AW-1:0] gran;
  logic [AW:0]   gran_ext;
  logic [AW:0]   free_pos;
  logic          free_bad_in;
  logic [NW-1:0] need_in;
  logic [LW-1:0] cfg_sat;

  logic          pw_en, nw_en, ew_en;
  logic [LW-1:0] pw_idx, nw_idx, ew_idx;
  logic [LW-1:0] pw_dat, nw_dat, ew_dat;
  logic          pw_ram, nw_ram, ew_ram;

  // read side: anchor entry lives in flops, out-of-table reads give zero
  always_comb begin
    if (pos == '0) begin
      prev_v = anchor_prev;
      next_v = anchor_next;
      end_v  = anchor_end;
    end else if (pba_pkg::in_table(pos)) begin
      prev_v = prev_q;
      next_v = next_q;
      end_v  = end_q;
    end else begin
      prev_v = '0;
      next_v = '0;
      end_v  = '0;
    end
  end

  assign data_v   = DW'(end_v) + DW'(pba_pkg::HEADER_GRANULES);
  assign dend_v   = data_v + DW'(need);
  assign res_full = MW'(data_v) * MW'(pba_pkg::ALIGN_BYTES);

  assign gran        = AW'(address / pba_pkg::ALIGN_BYTES);
  assign gran_ext    = (AW+1)'(gran);
  assign free_pos    = gran_ext - (AW+1)'(pba_pkg::HEADER_GRANULES);
  assign free_bad_in = (gran_ext <= (AW+1)'(pba_pkg::HEADER_GRANULES)) ||
                       (free_pos >= (AW+1)'(pool_granules));
  assign need_in     = NW'((NW'(size_bytes) + NW'(pba_pkg::ALIGN_BYTES - 1))
                       / pba_pkg::ALIGN_BYTES);

  assign cfg_sat = (32'(cfg_value) > 32'(pba_pkg::POOL_GRANULES)) ?
                   LW'(pba_pkg::POOL_GRANULES) : cfg_value;

  assign sts.op_free   = op_free;
  assign sts.size_zero = size_zero;
  assign sts.free_bad  = free_bad;
  assign sts.fit       = (dend_v <= DW'(next_v));
  assign sts.walk_end  = (pos == '0) || (steps == SW'(pba_pkg::POOL_GRANULES));

  // write side
  always_comb begin
    pw_en  = 1'b0;
    pw_idx = '0;
    pw_dat = '0;
    nw_en  = 1'b0;
    nw_idx = '0;
    nw_dat = '0;
    ew_en  = 1'b0;
    ew_idx = hdr_q;
    ew_dat = dend_q;
    if (cmd.splice1) begin
      nw_en  = 1'b1;
      nw_idx = pos;
      nw_dat = hdr_q;
      pw_en  = 1'b1;
      pw_idx = hdr_q;
      pw_dat = pos;
      ew_en  = 1'b1;
    end
    if (cmd.splice2) begin
      nw_en  = 1'b1;
      nw_idx = hdr_q;
      nw_dat = nxt_q;
      pw_en  = (nxt_q < pool_granules);
      pw_idx = nxt_q;
      pw_dat = hdr_q;
    end
    if (cmd.unlink) begin
      nw_en  = 1'b1;
      nw_idx = prev_v;
      nw_dat = next_v;
      pw_en  = (next_v < pool_granules);
      pw_idx = next_v;
      pw_dat = prev_v;
    end
  end

  assign pw_ram = pw_en && (pw_idx != '0) && pba_pkg::in_table(pw_idx);
  assign nw_ram = nw_en && (nw_idx != '0) && pba_pkg::in_table(nw_idx);
  assign ew_ram = ew_en && (ew_idx != '0) && pba_pkg::in_table(ew_idx);

  pba_ram #(.WIDTH(LW), .DEPTH(pba_pkg::POOL_GRANULES)) u_prev (
    .clk   (clk),
    .we    (pw_ram),
    .waddr (pw_idx[IW-1:0]),
    .wdata (pw_dat),
    .raddr (pos[IW-1:0]),
    .rdata (prev_q)
  );

  pba_ram #(.WIDTH(LW), .DEPTH(pba_pkg::POOL_GRANULES)) u_next (
    .clk   (clk),
    .we    (nw_ram),
    .waddr (nw_idx[IW-1:0]),
    .wdata (nw_dat),
    .raddr (pos[IW-1:0]),
    .rdata (next_q)
  );

  pba_ram #(.WIDTH(LW), .DEPTH(pba_pkg::POOL_GRANULES)) u_end (
    .clk   (clk),
    .we    (ew_ram),
    .waddr (ew_idx[IW-1:0]),
    .wdata (ew_dat),
    .raddr (pos[IW-1:0]),
    .rdata (end_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_granules <= LW'(pba_pkg::POOL_GRANULES);
      anchor_prev   <= '0;
      anchor_next   <= LW'(pba_pkg::POOL_GRANULES);
      anchor_end    <= LW'(pba_pkg::HEADER_GRANULES);
      last_header   <= '0;
      ok            <= 1'b0;
    end else if (cfg_we) begin
      pool_granules <= cfg_sat;
      anchor_prev   <= '0;
      anchor_next   <= cfg_sat;
      anchor_end    <= LW'(pba_pkg::HEADER_GRANULES);
      last_header   <= '0;
    end else begin
      if (pw_en && pw_idx == '0) begin
        anchor_prev <= pw_dat;
      end
      if (nw_en && nw_idx == '0) begin
        anchor_next <= nw_dat;
      end
      if (ew_en && ew_idx == '0) begin
        anchor_end <= ew_dat;
      end
      if (cmd.splice1 && (hdr_q > LW'(last_header))) begin
        last_header <= hdr_q[IW-1:0];
      end
      if (cmd.unlink && (pos == LW'(last_header))) begin
        last_header <= prev_v[IW-1:0];
      end
      if (cmd.rsp_load) begin
        ok <= cmd.rsp_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_free   <= (operation == pba_pkg::OP_FREE);
      size_zero <= (size_bytes == '0);
      free_bad  <= free_bad_in;
      need      <= need_in;
      steps     <= '0;
      pos       <= (operation == pba_pkg::OP_FREE) ? free_pos[LW-1:0] : LW'(last_header);
    end else if (cmd.step) begin
      pos   <= prev_v;
      steps <= steps + SW'(1);
    end
    if (cmd.latch) begin
      hdr_q    <= end_v;
      nxt_q    <= next_v;
      dend_q   <= dend_v[LW-1:0];
      res_addr <= res_full[AW-1:0];
    end
    if (cmd.rsp_load) begin
      address_out <= (cmd.rsp_ok && !op_free) ? res_addr : '0;
    end
  end

  `PBA_ASSERT(a_fit_addr, cmd.latch && sts.fit |=> res_addr != '0)
  `PBA_ASSERT(a_latch_alloc, cmd.latch |-> !op_free)
  `PBA_ASSERT_ALWAYS(a_pool_bound, rst || (32'(pool_granules) <= 32'(pba_pkg::POOL_GRANULES)))

endmodule

// ===== rtl/pool_block_allocator.sv =====
// pool_block_allocator: first-fit allocator over a pool of 8-byte granules.
// request channel carries one item: operation (0 allocate, 1 free), size_bytes
// and address. response carries address_out and ok, exactly one per item.
// Configuration: APB write of register 0 (pool_granules, byte address 0) sets
// the pool length, saturated to 4096, and re-initializes the anchor header.
// Throughput: one item in flight. An allocate visits headers backward from
// the last one, with one table read and one fit check on the registered
// read data per header, then two splice writes. Size zero or a free
// outside the pool answers ok = 0.
// Results sit in an output register: the next item is accepted while a
// result waits, but a result is only loaded once the previous one is taken,
// so a stalled receiver holds the block after one more item.
// Reset: synchronous; pool length 4096 and the anchor header restored at
// once, no clearing pass. Link tables are three 4096 x 13 RAMs; the anchor
// entry is held in flops.
module pool_block_allocator (
  input  logic                          clk,
  input  logic                          rst,
  pba_req_if.sink                       request,
  pba_rsp_if.source                     response,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pba_pkg::PADDR_W-1:0]   paddr,
  input  logic [pba_pkg::PDATA_W-1:0]   pwdata,
  output logic [pba_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  pba_pkg::pba_cmd_t                cmd;
  pba_pkg::pba_sts_t                sts;
  logic                             cfg_we;
  logic [pba_pkg::LINK_W-1:0]       pool_granules;
  logic [pba_pkg::REG_IDX_W-1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[pba_pkg::PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready &&
                   (reg_idx == pba_pkg::REG_POOL_GRANULES);
  assign prdata  = (reg_idx == pba_pkg::REG_POOL_GRANULES) ?
                   pba_pkg::PDATA_W'(pool_granules) : '0;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pba_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (request.operation),
    .size_bytes    (request.size_bytes),
    .address       (request.address),
    .cfg_we        (cfg_we),
    .cfg_value     (pwdata[pba_pkg::LINK_W-1:0]),
    .pool_granules (pool_granules),
    .address_out   (response.address_out),
    .ok            (response.ok)
  );

endmodule
